// ===== rtl/core/e2c_pkg.sv =====
// Shared types, constants and tables for the epoch-seconds-to-calendar converter.
// Holds the microcode layout, the control program and the month-length table.
// No dependencies; imported by every other file of the block.
package e2c_pkg;

  localparam int unsigned STEP_W = 4;

  // Reciprocals for constant division: t/60 = (t*RECIP60)>>37, t/3 = (t*RECIP3)>>33
  localparam logic [31:0] RECIP60 = 32'h8888_8889;
  localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;

  // Calendar start point and residues of the first year
  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [1:0]  EPOCH_MOD4   = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
  localparam logic [6:0]  LAST_MOD100  = 7'd99;
  localparam logic [8:0]  LAST_MOD400  = 9'd399;

  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [11:0] LAST_YEAR = 12'd2106;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL60,
    OP_MUL24,
    OP_DIV60_SEC,
    OP_DIV60_MIN,
    OP_DIV24_HOUR,
    OP_YINIT,
    OP_YSTEP,
    OP_MSTEP,
    OP_EMIT
  } e2c_op_t;

  // Sequencing: stay on the step while the condition holds, else go to target
  typedef enum logic [2:0] {
    COND_GO,
    COND_WAIT_IN,
    COND_LOOP_YEAR,
    COND_LOOP_MONTH,
    COND_WAIT_OUT
  } e2c_cond_t;

  typedef struct packed {
    e2c_op_t            op;
    e2c_cond_t          cond;
    logic [STEP_W-1:0]  target;
  } e2c_ctl_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic year_more;
    logic month_more;
    logic out_busy;
  } e2c_flags_t;

  // Control program
  function automatic e2c_ctl_t e2c_rom(input logic [STEP_W-1:0] step);
    e2c_ctl_t w;
    unique case (step)
      4'd0:    w = '{op: OP_LOAD,       cond: COND_WAIT_IN,    target: 4'd1};
      4'd1:    w = '{op: OP_MUL60,      cond: COND_GO,         target: 4'd2};
      4'd2:    w = '{op: OP_DIV60_SEC,  cond: COND_GO,         target: 4'd3};
      4'd3:    w = '{op: OP_MUL60,      cond: COND_GO,         target: 4'd4};
      4'd4:    w = '{op: OP_DIV60_MIN,  cond: COND_GO,         target: 4'd5};
      4'd5:    w = '{op: OP_MUL24,      cond: COND_GO,         target: 4'd6};
      4'd6:    w = '{op: OP_DIV24_HOUR, cond: COND_GO,         target: 4'd7};
      4'd7:    w = '{op: OP_YINIT,      cond: COND_GO,         target: 4'd8};
      4'd8:    w = '{op: OP_YSTEP,      cond: COND_LOOP_YEAR,  target: 4'd9};
      4'd9:    w = '{op: OP_MSTEP,      cond: COND_LOOP_MONTH, target: 4'd10};
      4'd10:   w = '{op: OP_EMIT,       cond: COND_WAIT_OUT,   target: 4'd0};
      default: w = '{op: OP_NOP,        cond: COND_GO,         target: 4'd0};
    endcase
    return w;
  endfunction

  // Days in a month, February by the leap flag
  function automatic logic [4:0] e2c_month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/e2c_useq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on e2c_pkg for the control word layout and the program.
module e2c_useq
  import e2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  e2c_flags_t flags_i,
  output e2c_ctl_t   ctl_o
);

  logic [STEP_W-1:0] pc_r, pc_nxt;
  logic              stay;

  // Fetch the control word of the current step
  assign ctl_o = e2c_rom(pc_r);

  // Decide whether to hold on this step
  always_comb begin
    unique case (ctl_o.cond)
      COND_GO:         stay = 1'b0;
      COND_WAIT_IN:    stay = !flags_i.in_valid;
      COND_LOOP_YEAR:  stay = flags_i.year_more;
      COND_LOOP_MONTH: stay = flags_i.month_more;
      COND_WAIT_OUT:   stay = flags_i.out_busy;
      default:         stay = 1'b0;
    endcase
    pc_nxt = stay ? pc_r : ctl_o.target;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // A transfer in is always followed by the first multiply
  a_load_then_mul : assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_o.op == OP_LOAD && flags_i.in_valid) |=> (ctl_o.op == OP_MUL60))
    else $error("load step not followed by multiply");

  // The year loop only exits into the month loop
  a_year_exit : assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_o.op == OP_YSTEP && !flags_i.year_more) |=> (ctl_o.op == OP_MSTEP))
    else $error("year loop exit went astray");

endmodule

// ===== rtl/core/e2c_dpath.sv =====
// Datapath: reciprocal multiplier, remainder extraction, year and month walks,
// and the output register. Driven one operation per cycle by e2c_useq; uses e2c_pkg.
module e2c_dpath
  import e2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  e2c_ctl_t    ctl_i,
  output e2c_flags_t  flags_o,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata
);

  logic [31:0] acc_r, acc_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [5:0]  sec_r, sec_nxt, min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [11:0] year_r, year_nxt;
  logic [1:0]  y4_r, y4_nxt;
  logic [6:0]  y100_r, y100_nxt;
  logic [8:0]  y400_r, y400_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [39:0] out_data_r, out_data_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [31:0] mul_a, mul_b;
  logic [26:0] q60;
  logic [32:0] q60x;
  logic [31:0] rem60;
  logic [30:0] q24;
  logic [34:0] q24x;
  logic [31:0] rem24;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        out_free;
  logic [4:0]  day;

  // Multiplier operands
  assign mul_a = (ctl_i.op == OP_MUL24) ? {3'b000, acc_r[31:3]} : acc_r;
  assign mul_b = (ctl_i.op == OP_MUL24) ? RECIP3 : RECIP60;

  // Quotient and remainder from the registered product
  assign q60   = prod_r[63:37];
  assign q60x  = {q60, 6'b0} - {4'b0, q60, 2'b0};
  assign rem60 = acc_r - q60x[31:0];
  assign q24   = prod_r[63:33];
  assign q24x  = {q24, 4'b0} + {1'b0, q24, 3'b0};
  assign rem24 = acc_r - q24x[31:0];

  // Gregorian leap rule from the running residues
  assign leap = (y4_r == 2'd0) && ((y100_r != 7'd0) || (y400_r == 9'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = e2c_month_len(month_r, leap);

  assign out_free = !out_valid_r || out_tready;
  assign day      = acc_r[4:0] + 5'd1;

  // Status for the sequencer
  assign flags_o.in_valid   = in_tvalid;
  assign flags_o.year_more  = (acc_r >= {23'b0, ylen});
  assign flags_o.month_more = (acc_r >= {27'b0, mlen}) && (month_r < MONTH_DEC);
  assign flags_o.out_busy   = !out_free;

  assign in_tready  = (ctl_i.op == OP_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Execute the current operation
  always_comb begin
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    sec_nxt       = sec_r;
    min_nxt       = min_r;
    hour_nxt      = hour_r;
    year_nxt      = year_r;
    y4_nxt        = y4_r;
    y100_nxt      = y100_r;
    y400_nxt      = y400_r;
    month_nxt     = month_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    unique case (ctl_i.op)
      OP_LOAD: begin
        if (in_tvalid) acc_nxt = in_tdata;
      end
      OP_MUL60, OP_MUL24: begin
        prod_nxt = mul_a * mul_b;
      end
      OP_DIV60_SEC: begin
        sec_nxt = rem60[5:0];
        acc_nxt = {5'b0, q60};
      end
      OP_DIV60_MIN: begin
        min_nxt = rem60[5:0];
        acc_nxt = {5'b0, q60};
      end
      OP_DIV24_HOUR: begin
        hour_nxt = rem24[4:0];
        acc_nxt  = {1'b0, q24};
      end
      OP_YINIT: begin
        year_nxt  = EPOCH_YEAR;
        y4_nxt    = EPOCH_MOD4;
        y100_nxt  = EPOCH_MOD100;
        y400_nxt  = EPOCH_MOD400;
        month_nxt = MONTH_JAN;
      end
      OP_YSTEP: begin
        // Drop one whole year while the day count covers it
        if (flags_o.year_more) begin
          acc_nxt  = acc_r - {23'b0, ylen};
          year_nxt = year_r + 12'd1;
          y4_nxt   = y4_r + 2'd1;
          y100_nxt = (y100_r == LAST_MOD100) ? 7'd0 : y100_r + 7'd1;
          y400_nxt = (y400_r == LAST_MOD400) ? 9'd0 : y400_r + 9'd1;
        end
      end
      OP_MSTEP: begin
        // Drop one whole month, stopping at December
        if (flags_o.month_more) begin
          acc_nxt   = acc_r - {27'b0, mlen};
          month_nxt = month_r + 4'd1;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_data_nxt  = {2'b00, sec_r, min_r, hour_r, day, month_r, year_r};
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the output valid under reset, payload registers free running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    sec_r      <= sec_nxt;
    min_r      <= min_nxt;
    hour_r     <= hour_nxt;
    year_r     <= year_nxt;
    y4_r       <= y4_nxt;
    y100_r     <= y100_nxt;
    y400_r     <= y400_nxt;
    month_r    <= month_nxt;
    out_data_r <= out_data_nxt;
  end

  // Year residue counter tracks the year itself
  a_mod4_track : assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_i.op == OP_YSTEP) |-> (y4_r == year_r[1:0]))
    else $error("year mod 4 residue out of step");

  // Year walk never runs past the last reachable year
  a_year_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_i.op == OP_YSTEP) |-> (year_r <= LAST_YEAR))
    else $error("year walk overran");

  // Month stays within January..December during the walk
  a_month_range : assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_i.op == OP_MSTEP) |-> (month_r >= MONTH_JAN && month_r <= MONTH_DEC))
    else $error("month out of range");

  // A delivered day of month is never zero
  a_day_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[20:16] != 5'd0))
    else $error("day of month is zero");

endmodule

// ===== rtl/core/epoch_seconds_to_calendar.sv =====
// Top level of the epoch-seconds-to-calendar converter.
// Instantiates the microcode sequencer e2c_useq and the datapath e2c_dpath; uses e2c_pkg.
//
//   channel | ports           | payload (low bit up)
//   --------+-----------------+----------------------------------------------------
//   input   | in_t{valid,...} | epoch_seconds[31:0]
//   output  | out_t{valid,..} | year[11:0] month[15:12] day_of_month[20:16]
//           |                 | hour[25:21] minute[31:26] second[37:32], 2 zero bits
//
// The year walk steps through the Y whole years past 1970 one at a time, and the month
// walk then steps through the M whole months (up to 11).
// The shared 32x32 reciprocal multiplier gives seconds, minutes and hours.
// Synchronous active-low reset returns the step counter to the load step and empties
// the output register; there is no clearing pass.
// A finished result waits in the output register; the next item is already taken
// and worked on, and stalls only at its own emit step while the old one is held.
module epoch_seconds_to_calendar
  import e2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // epoch_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // year, month, day_of_month, hour, minute, second
);

  e2c_ctl_t   ctl;
  e2c_flags_t flags;

  // Step through the control program
  e2c_useq u_useq (
    .clk     (clk),
    .rst_n   (rst_n),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  // Execute one operation per cycle
  e2c_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl),
    .flags_o    (flags),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
